// File: sv/rdt_pkg.sv
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared types and constants of the reference-counted domain table: command
// and status codes, default sizes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rdt_pkg;

	localparam int RDT_ENTRIES    = 128;
	localparam int RDT_KEY_BITS   = 64;
	localparam int RDT_COUNT_BITS = 16;

	// fixed widths of the word fields
	localparam int CMD_W   = 2;
	localparam int KEY_W   = 64;
	localparam int SLOT_W  = 7;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET   = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_PUT   = 2'd2,
		CMD_FREE  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_REF  = 3'd0,
		ST_NEW  = 3'd1,
		ST_MISS = 3'd2,
		ST_FULL = 3'd3,
		ST_DROP = 3'd4,
		ST_GONE = 3'd5,
		ST_SAT  = 3'd6
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr;
		logic scan;
		logic slot_chk;
		logic exec;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_put;
		logic clr_last;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

// File: sv/rdt_ram.sv
// ----------------------------------------------------------------------------
// rdt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/rdt_ctrl.sv
// ----------------------------------------------------------------------------
// rdt_ctrl
// Sequencer of the domain table: clearing pass after reset, word accept,
// table scan or slot read, and the final update with result load.
// ----------------------------------------------------------------------------
module rdt_ctrl import rdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SLOT  = 5'b01000,
		S_EXEC  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = stat.in_put ? S_SLOT : S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_EXEC;
				end
			end
			S_SLOT: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign ctl.load     = (state_q == S_IDLE) && in_valid;
	assign ctl.clr      = (state_q == S_CLEAR);
	assign ctl.scan     = (state_q == S_SCAN);
	assign ctl.slot_chk = (state_q == S_SLOT);
	assign ctl.exec     = (state_q == S_EXEC) && stat.out_free;

endmodule

// File: sv/rdt_dpath.sv
// ----------------------------------------------------------------------------
// rdt_dpath
// Datapath of the domain table: entry RAM, scan counters, match and free
// slot capture, count update and the result register.
// ----------------------------------------------------------------------------
module rdt_dpath import rdt_pkg::*; #(
	parameter int ENTRIES    = RDT_ENTRIES,
	parameter int KEY_BITS   = RDT_KEY_BITS,
	parameter int COUNT_BITS = RDT_COUNT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_cmd_t           ctl,
	output dp_stat_t           stat,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [KEY_W-1:0]   key,
	input  logic [SLOT_W-1:0]  slot,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [STAT_W-1:0]  status,
	output logic [SLOT_W-1:0]  slot_out,
	output logic [COUNT_W-1:0] count_out
);

	localparam int AW = $clog2(ENTRIES);
	localparam int WW = 1 + KEY_BITS + COUNT_BITS;
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	// ram word: {valid, key, count}
	logic          we;
	logic [AW-1:0] waddr;
	logic [WW-1:0] wdata;
	logic [AW-1:0] raddr;
	logic [WW-1:0] rdata;

	logic                  rd_valid;
	logic [KEY_BITS-1:0]   rd_key;
	logic [COUNT_BITS-1:0] rd_cnt;

	logic [AW-1:0]         addr_q;
	logic [AW-1:0]         chk_idx_q;
	cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic                  in_range_q;
	logic                  hit_q;
	logic [AW-1:0]         hit_idx_q;
	logic [KEY_BITS-1:0]   hit_key_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic                  free_q;
	logic [AW-1:0]         free_idx_q;

	logic                  out_valid_q;
	status_t               status_q;
	logic [SLOT_W-1:0]     slot_out_q;
	logic [COUNT_W-1:0]    count_out_q;

	logic [31:0]   slot_ext;
	logic [AW-1:0] slot_addr;
	logic          in_range;
	logic          in_put;
	logic          match;

	logic                  ex_we;
	logic [AW-1:0]         ex_addr;
	logic [WW-1:0]         ex_word;
	status_t               ex_status;
	logic [AW-1:0]         ex_idx;
	logic [COUNT_BITS-1:0] ex_cnt;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic [31:0]           idx_ext;
	logic [31:0]           cnt_ext;

	rdt_ram #(
		.WIDTH(WW),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_valid = rdata[WW-1];
	assign rd_key   = rdata[COUNT_BITS +: KEY_BITS];
	assign rd_cnt   = rdata[COUNT_BITS-1:0];

	assign slot_ext  = 32'(slot);
	assign slot_addr = slot_ext[AW-1:0];
	assign in_range  = (slot_ext < 32'(ENTRIES));
	assign in_put    = (cmd == CMD_PUT);

	assign match = rd_valid && (rd_cnt != '0) && (rd_key == key_q);

	assign raddr = ctl.load ? (in_put ? slot_addr : '0) : addr_q;

	assign we    = ctl.clr || (ctl.exec && ex_we);
	assign waddr = ctl.clr ? addr_q : ex_addr;
	assign wdata = ctl.clr ? '0 : ex_word;

	assign cnt_inc = hit_cnt_q + COUNT_BITS'(1);
	assign cnt_dec = hit_cnt_q - COUNT_BITS'(1);

	always_comb begin
		ex_we     = 1'b0;
		ex_addr   = hit_idx_q;
		ex_word   = '0;
		ex_status = ST_MISS;
		ex_idx    = '0;
		ex_cnt    = '0;
		unique case (cmd_q) inside
			CMD_GET, CMD_ALLOC: begin
				if (hit_q) begin
					ex_idx = hit_idx_q;
					if (&hit_cnt_q) begin
						ex_status = ST_SAT;
						ex_cnt    = hit_cnt_q;
					end else begin
						ex_we     = 1'b1;
						ex_word   = {1'b1, key_q, cnt_inc};
						ex_status = ST_REF;
						ex_cnt    = cnt_inc;
					end
				end else if (cmd_q == CMD_ALLOC) begin
					if (free_q) begin
						ex_we     = 1'b1;
						ex_addr   = free_idx_q;
						ex_word   = {1'b1, key_q, COUNT_BITS'(1)};
						ex_status = ST_NEW;
						ex_idx    = free_idx_q;
						ex_cnt    = COUNT_BITS'(1);
					end else begin
						ex_status = ST_FULL;
					end
				end
			end
			CMD_PUT, CMD_FREE: begin
				if (hit_q) begin
					ex_we  = 1'b1;
					ex_idx = hit_idx_q;
					if (cnt_dec == '0) begin
						// last reference gone, entry released
						ex_word   = '0;
						ex_status = ST_GONE;
					end else begin
						ex_word   = {1'b1, hit_key_q, cnt_dec};
						ex_status = ST_DROP;
						ex_cnt    = cnt_dec;
					end
				end
			end
			default: begin
				ex_status = ST_MISS;
			end
		endcase
	end

	assign idx_ext = 32'(ex_idx);
	assign cnt_ext = 32'(ex_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				addr_q <= addr_q + AW'(1);
			end else if (ctl.load) begin
				addr_q <= in_put ? slot_addr : AW'(1);
			end else if (ctl.scan && (addr_q != LAST)) begin
				addr_q <= addr_q + AW'(1);
			end
			if (ctl.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= cmd_t'(cmd);
			key_q      <= key[KEY_BITS-1:0];
			in_range_q <= in_range;
			chk_idx_q  <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
		end
		if (ctl.scan) begin
			if (match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= chk_idx_q;
				hit_key_q <= rd_key;
				hit_cnt_q <= rd_cnt;
			end
			if (!rd_valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= chk_idx_q;
			end
			if (chk_idx_q != LAST) begin
				chk_idx_q <= chk_idx_q + AW'(1);
			end
		end
		if (ctl.slot_chk) begin
			hit_q     <= in_range_q && rd_valid && (rd_cnt != '0);
			hit_idx_q <= addr_q;
			hit_key_q <= rd_key;
			hit_cnt_q <= rd_cnt;
		end
		if (ctl.exec) begin
			status_q    <= ex_status;
			slot_out_q  <= idx_ext[SLOT_W-1:0];
			count_out_q <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign stat.in_put    = in_put;
	assign stat.clr_last  = (addr_q == LAST);
	assign stat.scan_done = match || (chk_idx_q == LAST);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot_out  = slot_out_q;
	assign count_out = count_out_q;

endmodule

// File: sv/refcounted_domain_table.sv
// ----------------------------------------------------------------------------
// refcounted_domain_table
// Reference-counted table of domains keyed by page-directory address, with
// get, alloc, put and free commands and one result word per command.
// ----------------------------------------------------------------------------
// After reset the block clears its entry RAM, one entry per cycle, with
// in_ready low. Entries live in a single RAM with one read port. A put
// reads its slot directly; get, alloc and free scan for their key one
// entry per cycle from slot 0 up and stop at the matching entry, so a key
// that is not present, including every alloc that claims a new slot,
// takes a scan of the whole table. The result word is registered, so the
// next command word is taken while a result still waits on out_ready.
module refcounted_domain_table import rdt_pkg::*; #(
	parameter int ENTRIES    = RDT_ENTRIES,
	parameter int KEY_BITS   = RDT_KEY_BITS,
	parameter int COUNT_BITS = RDT_COUNT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [KEY_W-1:0]   key,
	input  logic [SLOT_W-1:0]  slot,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [STAT_W-1:0]  status,
	output logic [SLOT_W-1:0]  slot_out,
	output logic [COUNT_W-1:0] count_out
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	rdt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.ctl     (ctl)
	);

	rdt_dpath #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.cmd      (cmd),
		.key      (key),
		.slot     (slot),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.slot_out (slot_out),
		.count_out(count_out)
	);

`ifndef SYNTHESIS
	// one step per cycle from the sequencer
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.clr, ctl.scan, ctl.slot_chk, ctl.exec}))
		else $error("more than one datapath command at once");

	// a result is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// one word in work at a time
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("word accepted while another is in work");

	// misses and full table report no slot and no count
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_MISS || status == ST_FULL))
			|-> (slot_out == '0 && count_out == '0))
		else $error("miss result carries slot or count");

	// a released entry reports a zero count
	a_gone_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_GONE) |-> (count_out == '0))
		else $error("released entry with nonzero count");
`endif

endmodule
